// ===== hw/rtl/ffba_pkg.sv =====
// Shared types and constants of the first-fit block table allocator.
`default_nettype none
package ffba_pkg;

    localparam int NUM_BLOCKS_DEF  = 256;
    localparam int BLOCK_BYTES_DEF = 4096;

    localparam int ADDR_W    = 32;
    localparam int REQ_W     = 32;
    localparam int INUSE_W   = 9;
    localparam int FIRST_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [INUSE_W-1:0] BLOCKS_IN_USE_RST = 9'd256;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd1;

    // Table entry bits
    localparam int ENTRY_TAKEN_BIT    = 0;
    localparam int ENTRY_FIRST_BIT    = 1;
    localparam int ENTRY_HAS_NEXT_BIT = 2;

    typedef logic [2:0] entry_t;

    // Rotation control for the cell chain
    typedef struct packed {
        logic   shift;
        logic   load;
        entry_t entry;
    } rot_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ffba_if.sv =====
// Valid/ready channel interfaces for requests, grants and configuration writes.
`default_nettype none
interface ffba_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] request_bytes;

    modport source (output valid, output request_bytes, input ready);
    modport sink (input valid, input request_bytes, output ready);
endinterface

interface ffba_grant_if;
    logic        valid;
    logic        ready;
    logic        granted;
    logic [31:0] grant_address;
    logic [7:0]  first_block;

    modport source (output valid, output granted, output grant_address, output first_block,
                    input ready);
    modport sink (input valid, input granted, input grant_address, input first_block,
                  output ready);
endinterface

interface ffba_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ffba_cell.sv =====
// One block table entry, shifting toward the head of the chain.
`default_nettype none
module ffba_cell
    import ffba_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   shift,
    input  wire entry_t din,
    output entry_t      dout
);

    entry_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (shift)
        begin
            entry_reg <= din;
        end
    end

    assign dout = entry_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/ffba_chain.sv =====
// Ring of table cells; the head entry leaves and re-enters at the tail, optionally rewritten.
`default_nettype none
module ffba_chain
    import ffba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire rot_t rot,
    output entry_t    head
);

    entry_t cell_out [NUM_BLOCKS];
    entry_t tail_in;

    assign head    = cell_out[0];
    assign tail_in = rot.load ? rot.entry : cell_out[0];

    for (genvar k = 0; k < NUM_BLOCKS; k++)
    begin : g_cell
        entry_t din;
        if (k == NUM_BLOCKS - 1)
        begin : g_tail
            assign din = tail_in;
        end
        else
        begin : g_mid
            assign din = cell_out[k+1];
        end

        ffba_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (rot.shift),
            .din   (din),
            .dout  (cell_out[k])
        );
    end

endmodule
`default_nettype wire

// ===== hw/rtl/first_fit_block_table_allocator.sv =====
// Top level of the first-fit block table allocator.
// Each request takes one scan pass, in which the block table rotates once through a ring of cells
// past a single head comparator, and when a run is found a second pass that rewrites the run's
// entries as they pass the head. The request is accepted in the idle state, and the result
// register is loaded in the done state once the previous result has been taken. One request is
// in work at a time; a finished result waits in the output register while the next request
// starts. Configuration writes are always taken and must arrive while the block is idle. The
// table is all free after reset; nothing frees entries afterwards.
`default_nettype none
module first_fit_block_table_allocator
    import ffba_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    ffba_req_if.sink      req,
    ffba_grant_if.source  grant,
    ffba_cfg_if.sink      cfg
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int LIM_W = (IDX_W + 1 > INUSE_W) ? IDX_W + 1 : INUSE_W;
    localparam int RB_W  = REQ_W + 1;

    localparam logic [IDX_W-1:0]  POS_LAST  = IDX_W'(NUM_BLOCKS - 1);
    localparam logic [LIM_W-1:0]  LIM_MAX   = LIM_W'(NUM_BLOCKS);
    localparam logic [RB_W-1:0]   BLK_RB    = RB_W'(BLOCK_BYTES);
    localparam logic [ADDR_W-1:0] BLK_ADDR  = ADDR_W'(BLOCK_BYTES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_MARK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [REQ_W-1:0]   bytes_reg, bytes_next;
    logic [RB_W-1:0]    run_bytes_reg, run_bytes_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   start_reg, start_next;
    logic [IDX_W-1:0]   end_reg, end_next;
    logic [ADDR_W-1:0]  addr_pos_reg, addr_pos_next;
    logic [ADDR_W-1:0]  start_addr_reg, start_addr_next;
    logic [ADDR_W-1:0]  base_reg;
    logic [INUSE_W-1:0] blocks_reg;

    logic               out_valid_reg;
    logic               out_granted_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [FIRST_W-1:0] out_first_reg;

    rot_t               rot;
    entry_t             head;
    logic [LIM_W-1:0]   limit;
    logic               scan_active;
    logic               in_run;
    logic               out_load;
    logic [31:0]        start_wide;

    ffba_chain #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .rot   (rot),
        .head  (head)
    );

    assign limit = (LIM_W'(blocks_reg) > LIM_MAX) ? LIM_MAX : LIM_W'(blocks_reg);
    assign scan_active = !found_reg && (bytes_reg != '0) && (LIM_W'(pos_reg) < limit);
    assign in_run = (pos_reg >= start_reg) && (pos_reg <= end_reg);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || grant.ready);
    assign start_wide = 32'(start_reg);

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        bytes_next      = bytes_reg;
        run_bytes_next  = run_bytes_reg;
        found_next      = found_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        addr_pos_next   = addr_pos_reg;
        start_addr_next = start_addr_reg;
        rot.shift       = 1'b0;
        rot.load        = 1'b0;
        rot.entry       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    bytes_next     = req.request_bytes;
                    run_bytes_next = '0;
                    found_next     = 1'b0;
                    pos_next       = '0;
                    addr_pos_next  = base_reg;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rot.shift     = 1'b1;
                addr_pos_next = addr_pos_reg + BLK_ADDR;
                if (scan_active)
                begin
                    if (head[ENTRY_TAKEN_BIT])
                    begin
                        run_bytes_next = '0;
                    end
                    else
                    begin
                        if (run_bytes_reg == '0)
                        begin
                            start_next      = pos_reg;
                            start_addr_next = addr_pos_reg;
                        end
                        run_bytes_next = run_bytes_reg + BLK_RB;
                        if (run_bytes_next >= {1'b0, bytes_reg})
                        begin
                            found_next = 1'b1;
                            end_next   = pos_reg;
                        end
                    end
                end
                if (pos_reg == POS_LAST)
                begin
                    pos_next   = '0;
                    state_next = found_next ? ST_MARK : ST_DONE;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_MARK:
            begin
                rot.shift = 1'b1;
                rot.load  = in_run;
                rot.entry[ENTRY_TAKEN_BIT]    = 1'b1;
                rot.entry[ENTRY_FIRST_BIT]    = (pos_reg == start_reg);
                rot.entry[ENTRY_HAS_NEXT_BIT] = (pos_reg != end_reg);
                if (pos_reg == POS_LAST)
                begin
                    pos_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            blocks_reg    <= BLOCKS_IN_USE_RST;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            found_reg <= found_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (grant.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_BASE_ADDRESS:  base_reg   <= cfg.data;
                    REG_BLOCKS_IN_USE: blocks_reg <= cfg.data[INUSE_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bytes_reg      <= bytes_next;
        run_bytes_reg  <= run_bytes_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        addr_pos_reg   <= addr_pos_next;
        start_addr_reg <= start_addr_next;
        if (out_load)
        begin
            out_granted_reg <= found_reg;
            out_addr_reg    <= found_reg ? start_addr_reg : '0;
            out_first_reg   <= found_reg ? start_wide[FIRST_W-1:0] : '0;
        end
    end

    assign req.ready           = (state_reg == ST_IDLE);
    assign cfg.ready           = 1'b1;
    assign grant.valid         = out_valid_reg;
    assign grant.granted       = out_granted_reg;
    assign grant.grant_address = out_addr_reg;
    assign grant.first_block   = out_first_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/ffba_checker.sv =====
// Port-level checks of the allocator, bound to the top level.
`default_nettype none
module ffba_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        grant_valid,
    input wire logic        grant_ready,
    input wire logic        granted,
    input wire logic [31:0] grant_address,
    input wire logic [7:0]  first_block
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        grant_valid && !grant_ready |=> grant_valid && $stable(granted)
            && $stable(grant_address) && $stable(first_block))
        else $error("stalled grant item changed");

    // A failed request reports all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        grant_valid && !granted |-> grant_address == 32'd0 && first_block == 8'd0)
        else $error("failed grant carries non-zero fields");

    // One request in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

    // A new result appears only as the block returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(grant_valid) |-> req_ready)
        else $error("result loaded while a request is still in work");

endmodule

bind first_fit_block_table_allocator ffba_checker u_ffba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .grant_valid   (grant.valid),
    .grant_ready   (grant.ready),
    .granted       (grant.granted),
    .grant_address (grant.grant_address),
    .first_block   (grant.first_block)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the first-fit block table allocator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ffba_pkg::*;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int REPORT_LIMIT  = 10;
    localparam int ITEMS_PER_MIX = 125;

    // Indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam logic [ADDR_W-1:0] BLOCK_ALIGN_MASK = ~ADDR_W'(BLOCK_BYTES_DEF - 1);

    typedef struct packed {
        logic               granted;
        logic [ADDR_W-1:0]  grant_address;
        logic [FIRST_W-1:0] first_block;
    } grant_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ffba_req_if   req_ch ();
    ffba_grant_if grant_ch ();
    ffba_cfg_if   cfg_ch ();

    first_fit_block_table_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .grant (grant_ch),
        .cfg   (cfg_ch)
    );

    // Local copy of the allocator state
    entry_t             alloc_map [NUM_BLOCKS_DEF];
    logic [ADDR_W-1:0]  heap_base;
    logic [INUSE_W-1:0] heap_blocks;

    grant_t pending_grants [$];

    int     error_count    = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_request   = 0;
    int     hold_left      = 0;
    longint cycle_count    = 0;

    // Round up to whole blocks, find the first free run, mark it and build the grant
    function automatic grant_t allocate_run(input logic [REQ_W-1:0] bytes);
        longint unsigned need;
        longint unsigned limit;
        longint unsigned run;
        longint unsigned start;
        bit              found;
        entry_t          e;
        grant_t          res;
        need  = ({32'd0, bytes} + 64'(BLOCK_BYTES_DEF - 1)) / 64'(BLOCK_BYTES_DEF);
        limit = (heap_blocks > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : heap_blocks;
        run   = 0;
        start = 0;
        found = 1'b0;
        res   = '0;
        if (need != 0)
        begin
            for (longint unsigned i = 0; i < limit; i++)
            begin
                if (alloc_map[i][ENTRY_TAKEN_BIT])
                begin
                    run = 0;
                    continue;
                end
                if (run == 0)
                    start = i;
                run++;
                if (run == need)
                begin
                    found = 1'b1;
                    break;
                end
            end
        end
        if (found)
        begin
            for (longint unsigned j = start; j < start + need; j++)
            begin
                e = '0;
                e[ENTRY_TAKEN_BIT] = 1'b1;
                if (j == start)
                    e[ENTRY_FIRST_BIT] = 1'b1;
                if (j != start + need - 1)
                    e[ENTRY_HAS_NEXT_BIT] = 1'b1;
                alloc_map[j] = e;
            end
            res.granted       = 1'b1;
            res.grant_address = heap_base + ADDR_W'(start * BLOCK_BYTES_DEF);
            res.first_block   = FIRST_W'(start);
        end
        return res;
    endfunction

    // Mostly small requests so the table fills slowly; some zero, huge and odd sizes
    function automatic logic [REQ_W-1:0] random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        else if (pick < 20)
            return $urandom;
        else if (pick < 30)
            return REQ_W'($urandom_range(1, 4) * BLOCK_BYTES_DEF);
        else if (pick < 40)
            return REQ_W'($urandom_range(1, 16 * BLOCK_BYTES_DEF));
        else
            return REQ_W'($urandom_range(1, BLOCK_BYTES_DEF));
    endfunction

    // Drop the request valid and wait until every grant has come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_grants.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == REG_BASE_ADDRESS)
            heap_base = data;
        else if (idx == REG_BLOCKS_IN_USE)
            heap_blocks = data[INUSE_W-1:0];
    endtask

    task automatic configure(input logic [ADDR_W-1:0] base, input logic [31:0] in_use);
        drain();
        write_reg(REG_BASE_ADDRESS, base);
        write_reg(REG_BLOCKS_IN_USE, in_use);
        write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_request(input logic [REQ_W-1:0] bytes);
        int gap = 0;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < 50)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.request_bytes <= bytes;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_grants.push_back(allocate_run(bytes));
    endtask

    // Grant checker
    always @(posedge clk)
    begin
        grant_t got;
        grant_t want;
        if (rst_n && grant_ch.valid && grant_ch.ready)
        begin
            got.granted       = grant_ch.granted;
            got.grant_address = grant_ch.grant_address;
            got.first_block   = grant_ch.first_block;
            if (pending_grants.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected grant: granted=%0d addr=%h first=%0d",
                             got.granted, got.grant_address, got.first_block);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (got.granted !== want.granted || got.grant_address !== want.grant_address
                    || got.first_block !== want.first_block)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("grant mismatch: expected granted=%0d addr=%h first=%0d, %s",
                                 want.granted, want.grant_address, want.first_block,
                                 $sformatf("got granted=%0d addr=%h first=%0d",
                                           got.granted, got.grant_address, got.first_block));
                end
            end
        end
    end

    // Grant receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            grant_ch.ready <= 1'b0;
        end
        else
            grant_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request('0);
        send_request(32'd1);
        send_request(32'd4096);
        send_request(32'd4097);
        send_request(32'hFFFF_FFFF);
        send_request(REQ_W'(NUM_BLOCKS_DEF * BLOCK_BYTES_DEF));
        send_request(32'd4095);
    endtask

    task automatic test_register_extremes();
        // Base near the top so the grant address wraps
        configure(32'hFFFF_F000, 32'd256);
        send_request(32'd8192);
        // Empty heap: everything fails
        configure(32'h0000_0ABC, 32'd0);
        send_request(32'd1);
        send_request('0);
        // Heap edge just past the used blocks
        configure(32'h8000_0000, 32'd9);
        send_request(32'd12288);
        send_request(32'd8193);
        send_request(32'd1);
        // Over-range extent clamps to the table size
        configure(32'h5555_5000, 32'hFFFF_FFFF);
        send_request(32'd1);
        send_request(REQ_W'(NUM_BLOCKS_DEF * BLOCK_BYTES_DEF));
        send_request(32'h7FFF_FFFF);
        send_request(32'hAAAA_AAAA);
        send_request(32'h0000_1001);
    endtask

    task automatic test_backpressure();
        configure($urandom & BLOCK_ALIGN_MASK, 32'd256);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 2500;
        repeat (8)
            send_request(REQ_W'($urandom_range(0, BLOCK_BYTES_DEF)));
    endtask

    task automatic test_random_traffic();
        int send_mix  [4] = '{0, 54, 0, 23};
        int recv_mix  [4] = '{0, 0, 54, 23};
        int heap_mix  [4] = '{64, 128, 192, 256};
        logic [ADDR_W-1:0] base;
        for (int p = 0; p < 4; p++)
        begin
            base = ($urandom_range(3) == 0) ? $urandom : ($urandom & BLOCK_ALIGN_MASK);
            configure(base, heap_mix[p]);
            send_idle_pct  = send_mix[p];
            recv_stall_pct = recv_mix[p];
            repeat (ITEMS_PER_MIX)
                send_request(random_request());
        end
    endtask

    // Request the size of the free tail up to the last entry, then a one-byte and a zero-byte request
    task automatic test_fill_to_end();
        int tail = 0;
        configure($urandom & BLOCK_ALIGN_MASK, NUM_BLOCKS_DEF);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (tail < NUM_BLOCKS_DEF && !alloc_map[NUM_BLOCKS_DEF-1-tail][ENTRY_TAKEN_BIT])
            tail++;
        if (tail > 0)
            send_request(REQ_W'(tail * BLOCK_BYTES_DEF));
        send_request(32'd1);
        send_request('0);
    endtask

    initial
    begin
        req_ch.valid         = 1'b0;
        req_ch.request_bytes = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        grant_ch.ready       = 1'b0;
        heap_base            = '0;
        heap_blocks          = BLOCKS_IN_USE_RST;
        foreach (alloc_map[i])
            alloc_map[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        test_fill_to_end();

        drain();
        repeat (2 * NUM_BLOCKS_DEF + 8) @(posedge clk);
        if (error_count == 0 && pending_grants.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
